// ----- src/lex_pkg.sv -----
package lex_pkg;

    // width of a number token's value
    localparam int VALUE_BITS = 31;

    // records held between the classifier and the emitter
    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [2:0] {
        M_IDLE = 3'd0,
        M_NUM  = 3'd1,
        M_NAME = 3'd2,
        M_EQ   = 3'd3,
        M_GT   = 3'd4,
        M_LT   = 3'd5,
        M_BANG = 3'd6,
        M_HALT = 3'd7
    } t_mode;

    typedef enum logic [2:0] {
        K_EOF  = 3'd0,
        K_EOL  = 3'd1,
        K_NUM  = 3'd2,
        K_NAME = 3'd3,
        K_SYM  = 3'd4,
        K_SYM2 = 3'd5,
        K_ERR  = 3'd6
    } t_kind;

    typedef struct packed {
        logic [7:0] ch;
        logic       end_of_input;
    } t_in_beat;

    typedef struct packed {
        t_kind                  kind;
        logic [VALUE_BITS-1:0]  value;
        logic                   name_last;
        logic                   last;
    } t_out_beat;

    // one token without its position flag
    typedef struct packed {
        t_kind                  kind;
        logic [VALUE_BITS-1:0]  value;
        logic                   name_last;
    } t_tok;

    // all tokens caused by one input item
    typedef struct packed {
        logic two;
        t_tok tok0;
        t_tok tok1;
    } t_rec;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

// ----- src/lex_front.sv -----
module lex_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  lex_pkg::t_in_beat i_beat,
    output logic             o_push,
    output lex_pkg::t_rec    o_rec
);

    localparam int VB = lex_pkg::VALUE_BITS;

    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_NL    = 8'd10;
    localparam logic [7:0] CH_VT    = 8'd11;
    localparam logic [7:0] CH_FF    = 8'd12;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_BANG  = 8'd33;
    localparam logic [7:0] CH_PCT   = 8'd37;
    localparam logic [7:0] CH_LPAR  = 8'd40;
    localparam logic [7:0] CH_RPAR  = 8'd41;
    localparam logic [7:0] CH_STAR  = 8'd42;
    localparam logic [7:0] CH_PLUS  = 8'd43;
    localparam logic [7:0] CH_MINUS = 8'd45;
    localparam logic [7:0] CH_SLASH = 8'd47;
    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_NINE  = 8'd57;
    localparam logic [7:0] CH_SEMI  = 8'd59;
    localparam logic [7:0] CH_LT    = 8'd60;
    localparam logic [7:0] CH_EQ    = 8'd61;
    localparam logic [7:0] CH_GT    = 8'd62;
    localparam logic [7:0] CH_UC_A  = 8'd65;
    localparam logic [7:0] CH_UC_Z  = 8'd90;
    localparam logic [7:0] CH_LC_A  = 8'd97;
    localparam logic [7:0] CH_LC_Z  = 8'd122;
    localparam logic [7:0] CH_LBRC  = 8'd123;
    localparam logic [7:0] CH_RBRC  = 8'd125;

    localparam logic [VB-1:0] VAL_MAX = {VB{1'b1}};

    lex_pkg::t_mode  r_mode, n_mode;
    logic [VB-1:0]   r_acc,  n_acc;
    logic [7:0]      r_held, n_held;

    logic [7:0]      c;
    logic            eoi;
    logic            is_digit, is_alpha, is_space, is_simple;
    logic            restart;
    logic [VB-1:0]   c_val;
    logic [VB+3:0]   acc_wide;
    logic [VB-1:0]   acc_sat;
    lex_pkg::t_mode  s_mode;
    logic            s_emit;
    lex_pkg::t_tok   s_tok;
    logic            p_emit, sec_emit;
    lex_pkg::t_tok   p_tok, sec_tok;
    logic [7:0]      p_char;

    assign c     = i_beat.ch;
    assign eoi   = i_beat.end_of_input;
    assign c_val = {{(VB-8){1'b0}}, c};

    assign is_digit  = (c >= CH_ZERO) && (c <= CH_NINE);
    assign is_alpha  = ((c >= CH_LC_A) && (c <= CH_LC_Z)) ||
                       ((c >= CH_UC_A) && (c <= CH_UC_Z));
    assign is_space  = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_VT) ||
                       (c == CH_FF) || (c == CH_CR);
    assign is_simple = (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_STAR) ||
                       (c == CH_SLASH) || (c == CH_PCT) || (c == CH_SEMI) ||
                       (c == CH_LPAR) || (c == CH_RPAR) || (c == CH_LBRC) ||
                       (c == CH_RBRC);

    // acc * 10 + digit, saturating
    assign acc_wide = {1'b0, r_acc, 3'b000} + {3'b000, r_acc, 1'b0} +
                      {{(VB-4){1'b0}}, (c - CH_ZERO)};
    assign acc_sat  = (acc_wide > {4'b0000, VAL_MAX}) ? VAL_MAX : acc_wide[VB-1:0];

    // the byte begins a fresh token
    always_comb begin
        restart = 1'b0;
        if (!eoi) begin
            case (r_mode)
                lex_pkg::M_IDLE: restart = 1'b1;
                lex_pkg::M_NUM:  restart = !is_digit;
                lex_pkg::M_NAME: restart = !(is_digit || is_alpha);
                lex_pkg::M_EQ,
                lex_pkg::M_GT,
                lex_pkg::M_LT:   restart = (c != CH_EQ);
                default:         restart = 1'b0;
            endcase
        end
    end

    // classification of a starting byte
    always_comb begin
        s_mode = lex_pkg::M_IDLE;
        s_emit = 1'b0;
        s_tok  = '{kind: lex_pkg::K_EOL, value: '0, name_last: 1'b0};
        if (is_space) begin
            s_mode = lex_pkg::M_IDLE;
        end else if (c == CH_NL) begin
            s_emit = 1'b1;
        end else if (is_digit) begin
            s_mode = lex_pkg::M_NUM;
        end else if (c == CH_EQ) begin
            s_mode = lex_pkg::M_EQ;
        end else if (c == CH_GT) begin
            s_mode = lex_pkg::M_GT;
        end else if (c == CH_LT) begin
            s_mode = lex_pkg::M_LT;
        end else if (c == CH_BANG) begin
            s_mode = lex_pkg::M_BANG;
        end else if (is_simple) begin
            s_emit = 1'b1;
            s_tok  = '{kind: lex_pkg::K_SYM, value: c_val, name_last: 1'b0};
        end else if (is_alpha) begin
            s_mode = lex_pkg::M_NAME;
        end else begin
            s_mode = lex_pkg::M_HALT;
            s_emit = 1'b1;
            s_tok  = '{kind: lex_pkg::K_ERR, value: c_val, name_last: 1'b0};
        end
    end

    // next state
    always_comb begin
        n_mode = r_mode;
        n_acc  = r_acc;
        n_held = r_held;
        if (r_mode != lex_pkg::M_HALT) begin
            if (eoi) begin
                n_mode = lex_pkg::M_IDLE;
            end else if (restart) begin
                n_mode = s_mode;
                if (is_digit) begin
                    n_acc = {{(VB-8){1'b0}}, (c - CH_ZERO)};
                end
                if (is_alpha) begin
                    n_held = c;
                end
            end else begin
                case (r_mode)
                    lex_pkg::M_NUM:  n_acc  = acc_sat;
                    lex_pkg::M_NAME: n_held = c;
                    default:         n_mode = lex_pkg::M_IDLE;
                endcase
            end
        end
    end

    always_comb begin
        case (r_mode)
            lex_pkg::M_EQ: p_char = CH_EQ;
            lex_pkg::M_GT: p_char = CH_GT;
            default:       p_char = CH_LT;
        endcase
    end

    // tokens caused by this item
    always_comb begin
        p_emit   = 1'b0;
        p_tok    = '{kind: lex_pkg::K_EOF, value: '0, name_last: 1'b0};
        sec_emit = 1'b0;
        sec_tok  = '{kind: lex_pkg::K_EOF, value: '0, name_last: 1'b0};
        case (r_mode)
            lex_pkg::M_NUM: begin
                p_emit = eoi || !is_digit;
                p_tok  = '{kind: lex_pkg::K_NUM, value: r_acc, name_last: 1'b0};
            end
            lex_pkg::M_NAME: begin
                p_emit = 1'b1;
                p_tok  = '{kind: lex_pkg::K_NAME,
                           value: {{(VB-8){1'b0}}, r_held},
                           name_last: eoi || !(is_alpha || is_digit)};
            end
            lex_pkg::M_EQ,
            lex_pkg::M_GT,
            lex_pkg::M_LT: begin
                p_emit = 1'b1;
                p_tok  = '{kind: (!eoi && (c == CH_EQ)) ? lex_pkg::K_SYM2 : lex_pkg::K_SYM,
                           value: {{(VB-8){1'b0}}, p_char}, name_last: 1'b0};
            end
            lex_pkg::M_BANG: begin
                p_emit = 1'b1;
                p_tok  = '{kind: lex_pkg::K_SYM2,
                           value: {{(VB-8){1'b0}}, CH_BANG}, name_last: 1'b0};
            end
            default: p_emit = 1'b0;
        endcase
        if (r_mode != lex_pkg::M_HALT) begin
            if (eoi) begin
                sec_emit = 1'b1;
            end else if (restart) begin
                sec_emit = s_emit;
                sec_tok  = s_tok;
            end
        end
    end

    always_comb begin
        if (p_emit) begin
            o_rec = '{two: sec_emit, tok0: p_tok, tok1: sec_tok};
        end else begin
            o_rec = '{two: 1'b0, tok0: sec_tok, tok1: sec_tok};
        end
    end

    assign o_push = i_accept && (p_emit || sec_emit);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= lex_pkg::M_IDLE;
            r_acc  <= '0;
            r_held <= '0;
        end else if (i_accept) begin
            r_mode <= n_mode;
            r_acc  <= n_acc;
            r_held <= n_held;
        end
    end

endmodule

// ----- src/lex_queue.sv -----
module lex_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  lex_pkg::t_rec    i_rec,
    input  logic             i_pop,
    output lex_pkg::t_rec    o_rec,
    output lex_pkg::t_q_stat o_stat
);

    localparam int DEPTH = lex_pkg::QUEUE_DEPTH;
    localparam int PW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    lex_pkg::t_rec r_mem [DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_cnt;
    logic          do_push, do_pop;

    assign o_stat.full  = (r_cnt == CW'(DEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_rec        = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ----- src/lex_back.sv -----
module lex_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lex_pkg::t_rec     i_rec,
    input  lex_pkg::t_q_stat  i_stat,
    output logic              o_pop,
    output logic              o_valid,
    output lex_pkg::t_out_beat o_beat,
    input  logic              i_stall
);

    logic               r_valid, n_valid;
    logic               r_pend,  n_pend;
    lex_pkg::t_out_beat r_beat;
    lex_pkg::t_tok      r_tok1;
    logic               load;

    // output register free or being taken
    assign load  = !r_valid || !i_stall;
    assign o_pop = load && !r_pend && !i_stat.empty;

    always_comb begin
        n_valid = r_valid;
        n_pend  = r_pend;
        if (load) begin
            if (r_pend) begin
                n_valid = 1'b1;
                n_pend  = 1'b0;
            end else if (!i_stat.empty) begin
                n_valid = 1'b1;
                n_pend  = i_rec.two;
            end else begin
                n_valid = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pend  <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            if (r_pend) begin
                r_beat <= '{kind: r_tok1.kind, value: r_tok1.value,
                            name_last: r_tok1.name_last, last: 1'b1};
            end else if (!i_stat.empty) begin
                r_beat <= '{kind: i_rec.tok0.kind, value: i_rec.tok0.value,
                            name_last: i_rec.tok0.name_last, last: !i_rec.two};
                r_tok1 <= i_rec.tok1;
            end
        end
    end

    assign o_valid = r_valid;
    assign o_beat  = r_beat;

endmodule

// ----- src/statement_lexer.sv -----
// channel   direction  handshake                      beat
// in        input      i_in_valid / o_in_stall        ch, end_of_input
// out       output     o_out_valid / i_out_stall      kind, value, name_last, last
//
// an item is taken every cycle while the queue is not full; one that gives
// two tokens is split by the emitter into two output beats, the second marked last
// the first token is written into the queue when its item is taken, then loaded
// into the output register once that register is free or being taken
// reset is synchronous, active low: mode idle, accumulator, held char, queue clear
// the input stalls only when the four-record queue is full
module statement_lexer (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  lex_pkg::t_in_beat  i_in_data,
    output logic               o_in_stall,
    output logic               o_out_valid,
    output lex_pkg::t_out_beat o_out_data,
    input  logic               i_out_stall
);

    // handshake on the input side
    logic             in_accept;
    // classifier to queue
    logic             push;
    lex_pkg::t_rec    push_rec;
    // queue to emitter
    logic             pop;
    lex_pkg::t_rec    head_rec;
    lex_pkg::t_q_stat q_stat;

    // input is held back only by a full queue, never by the output side directly
    assign o_in_stall = q_stat.full;
    assign in_accept  = i_in_valid && !o_in_stall;

    // front: mode tracking, number accumulation, name hold-back, token building
    lex_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_accept),
        .i_beat   (i_in_data),
        .o_push   (push),
        .o_rec    (push_rec)
    );

    // short queue of per-item token records, so each side stalls on its own
    lex_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_rec    (push_rec),
        .i_pop    (pop),
        .o_rec    (head_rec),
        .o_stat   (q_stat)
    );

    // back: splits a record into one or two output beats and marks the last
    lex_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rec    (head_rec),
        .i_stat   (q_stat),
        .o_pop    (pop),
        .o_valid  (o_out_valid),
        .o_beat   (o_out_data),
        .i_stall  (i_out_stall)
    );

    // the second token of a pair is loaded straight behind the first
    a_pair_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.last) |=> o_out_valid)
        else $error("second beat of a pair missing");

    // end of file always closes its item
    a_eof_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.kind == lex_pkg::K_EOF)) |-> o_out_data.last)
        else $error("eof beat not flagged last");

    // only name characters carry the end-of-name flag
    a_name_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.name_last) |-> (o_out_data.kind == lex_pkg::K_NAME))
        else $error("name_last on a non-name beat");

    // a record is never pushed while the queue refuses it
    a_no_lost_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !q_stat.full)
        else $error("token record pushed into a full queue");

endmodule

// ----- tb/tb_statement_lexer.sv -----
`timescale 1ns / 100ps

module tb_statement_lexer;

    localparam int         VB              = lex_pkg::VALUE_BITS;
    localparam int         HALF_PERIOD     = 5;
    // long receiver hold-off, enough to fill the four-record queue many times over
    localparam int         HOLD_CYCLES     = 80;
    localparam int         ITEMS_PER_PHASE = 240;
    // idle time after the final drain, before the verdict is printed
    localparam int         DRAIN_CYCLES    = 10;
    // about 1000 items, at worst two tokens each behind a heavily stalling receiver,
    // so this timeout is a generous ceiling
    localparam longint     TIMEOUT_NS      = 5_000_000;

    localparam logic [7:0] CH_TAB = 8'd9;
    localparam logic [7:0] CH_NL  = 8'd10;
    localparam logic [7:0] CH_VT  = 8'd11;
    localparam logic [7:0] CH_FF  = 8'd12;
    localparam logic [7:0] CH_CR  = 8'd13;
    localparam logic [7:0] CH_SP  = 8'd32;
    localparam logic [7:0] CH_EQ  = 8'd61;

    // token predictor plus the queue of tokens still owed by the block
    class lex_scoreboard;
        lex_pkg::t_mode     mode;
        longint unsigned    number_acc;
        logic [7:0]         held_char;
        lex_pkg::t_out_beat item_toks[$];
        lex_pkg::t_out_beat owed_toks[$];
        int                 errors;

        function new();
            mode       = lex_pkg::M_IDLE;
            number_acc = 0;
            held_char  = '0;
            errors     = 0;
        endfunction

        function bit is_digit(logic [7:0] c);
            return c >= "0" && c <= "9";
        endfunction

        function bit is_letter(logic [7:0] c);
            return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
        endfunction

        function bit is_blank(logic [7:0] c);
            return c == CH_SP || c == CH_TAB || c == CH_VT || c == CH_FF || c == CH_CR;
        endfunction

        function bit is_single_sym(logic [7:0] c);
            case (c)
                "+", "-", "*", "/", "%", ";", "(", ")", "{", "}": return 1'b1;
                default: return 1'b0;
            endcase
        endfunction

        function logic [7:0] relation_char();
            if (mode == lex_pkg::M_EQ) return CH_EQ;
            if (mode == lex_pkg::M_GT) return ">";
            return "<";
        endfunction

        function void add_tok(lex_pkg::t_kind k, longint unsigned v, logic nl);
            lex_pkg::t_out_beat t;
            t.kind      = k;
            t.value     = VB'(v);
            t.name_last = nl;
            t.last      = 1'b0;
            item_toks.insert(item_toks.size(), t);
        endfunction

        // a byte seen with nothing pending
        function void open_token(logic [7:0] c);
            if (is_blank(c)) begin
                return;
            end else if (c == CH_NL) begin
                add_tok(lex_pkg::K_EOL, 0, 1'b0);
            end else if (is_digit(c)) begin
                number_acc = c - "0";
                mode       = lex_pkg::M_NUM;
            end else if (c == CH_EQ) begin
                mode = lex_pkg::M_EQ;
            end else if (c == ">") begin
                mode = lex_pkg::M_GT;
            end else if (c == "<") begin
                mode = lex_pkg::M_LT;
            end else if (c == "!") begin
                mode = lex_pkg::M_BANG;
            end else if (is_single_sym(c)) begin
                add_tok(lex_pkg::K_SYM, c, 1'b0);
            end else if (is_letter(c)) begin
                held_char = c;
                mode      = lex_pkg::M_NAME;
            end else begin
                add_tok(lex_pkg::K_ERR, c, 1'b0);
                mode = lex_pkg::M_HALT;
            end
        endfunction

        function void note_input(lex_pkg::t_in_beat b);
            longint unsigned digit;
            longint unsigned top;
            logic [7:0]      rel;
            item_toks.delete();
            top = (64'd1 << VB) - 1;
            if (mode == lex_pkg::M_HALT)
                return;
            if (b.end_of_input) begin
                case (mode)
                    lex_pkg::M_NUM:
                        add_tok(lex_pkg::K_NUM, number_acc, 1'b0);
                    lex_pkg::M_NAME:
                        add_tok(lex_pkg::K_NAME, held_char, 1'b1);
                    lex_pkg::M_EQ, lex_pkg::M_GT, lex_pkg::M_LT:
                        add_tok(lex_pkg::K_SYM, relation_char(), 1'b0);
                    lex_pkg::M_BANG:
                        add_tok(lex_pkg::K_SYM2, "!", 1'b0);
                    default: ;
                endcase
                add_tok(lex_pkg::K_EOF, 0, 1'b0);
                mode = lex_pkg::M_IDLE;
            end else begin
                case (mode)
                    lex_pkg::M_NUM: begin
                        if (is_digit(b.ch)) begin
                            digit = b.ch - "0";
                            // saturate rather than wrap
                            if (number_acc > (top - digit) / 10)
                                number_acc = top;
                            else
                                number_acc = number_acc * 10 + digit;
                        end else begin
                            add_tok(lex_pkg::K_NUM, number_acc, 1'b0);
                            mode = lex_pkg::M_IDLE;
                            open_token(b.ch);
                        end
                    end
                    lex_pkg::M_NAME: begin
                        if (is_letter(b.ch) || is_digit(b.ch)) begin
                            add_tok(lex_pkg::K_NAME, held_char, 1'b0);
                            held_char = b.ch;
                        end else begin
                            add_tok(lex_pkg::K_NAME, held_char, 1'b1);
                            mode = lex_pkg::M_IDLE;
                            open_token(b.ch);
                        end
                    end
                    lex_pkg::M_EQ, lex_pkg::M_GT, lex_pkg::M_LT: begin
                        rel  = relation_char();
                        mode = lex_pkg::M_IDLE;
                        if (b.ch == CH_EQ) begin
                            add_tok(lex_pkg::K_SYM2, rel, 1'b0);
                        end else begin
                            add_tok(lex_pkg::K_SYM, rel, 1'b0);
                            open_token(b.ch);
                        end
                    end
                    lex_pkg::M_BANG: begin
                        // byte after the bang is swallowed whatever it is
                        add_tok(lex_pkg::K_SYM2, "!", 1'b0);
                        mode = lex_pkg::M_IDLE;
                    end
                    default: begin
                        mode = lex_pkg::M_IDLE;
                        open_token(b.ch);
                    end
                endcase
            end
            foreach (item_toks[i]) begin
                lex_pkg::t_out_beat t;
                t      = item_toks[i];
                t.last = (i == item_toks.size() - 1);
                owed_toks.insert(owed_toks.size(), t);
            end
        endfunction

        function void check_result(lex_pkg::t_out_beat got);
            lex_pkg::t_out_beat want;
            if (owed_toks.size() == 0) begin
                $display("%0t: unexpected beat kind %0d value %0d name_last %0b last %0b",
                         $time, got.kind, got.value, got.name_last, got.last);
                errors++;
                return;
            end
            want = owed_toks.pop_front();
            if (got.kind !== want.kind) begin
                $display("%0t: kind expected %0d got %0d", $time, want.kind, got.kind);
                errors++;
            end
            if (got.value !== want.value) begin
                $display("%0t: value expected %0d got %0d", $time, want.value, got.value);
                errors++;
            end
            if (got.name_last !== want.name_last) begin
                $display("%0t: name_last expected %0b got %0b", $time,
                         want.name_last, got.name_last);
                errors++;
            end
            if (got.last !== want.last) begin
                $display("%0t: last expected %0b got %0b", $time, want.last, got.last);
                errors++;
            end
        endfunction

        function int pending();
            return owed_toks.size();
        endfunction
    endclass

    // all block inputs start at known values
    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    lex_pkg::t_in_beat  i_in_data   = '0;
    logic               i_out_stall = 1'b0;
    logic               o_in_stall;
    logic               o_out_valid;
    lex_pkg::t_out_beat o_out_data;

    lex_scoreboard sb;

    // idling percentages for the current phase, written by the stimulus only
    int send_idle_pct = 0;
    int out_stall_pct = 0;
    // hold-off requests from the stimulus; the receiver counts its own cycles
    int hold_reqs     = 0;
    int hold_taken    = 0;
    int hold_left     = 0;
    int items_sent    = 0;

    string single_syms = "+-*/%;(){}";
    string rel_syms    = "=<>";

    statement_lexer u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

    initial begin
        forever #HALF_PERIOD i_clk = ~i_clk;
    end

    // beats on both channels are taken at the rising edge; the input beat is noted
    // first although it cannot produce a token in the same cycle
    always @(posedge i_clk) begin
        if (i_rst_n && sb != null) begin
            if (i_in_valid && !o_in_stall)
                sb.note_input(i_in_data);
            if (o_out_valid && !i_out_stall)
                sb.check_result(o_out_data);
        end
    end

    // receiver: random stall, or a long hold-off once asked for
    always @(negedge i_clk) begin
        if (hold_reqs != hold_taken) begin
            hold_taken = hold_reqs;
            hold_left  = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < out_stall_pct);
        end
    end

    // offer one beat, idling first at random, and return once it is taken
    task automatic send_beat(logic [7:0] c, logic eoi);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid             <= 1'b1;
        i_in_data.ch           <= c;
        i_in_data.end_of_input <= eoi;
        do @(posedge i_clk); while (o_in_stall);
        items_sent++;
    endtask

    task automatic send_char(logic [7:0] c);
        send_beat(c, 1'b0);
    endtask

    // end of input carries a random byte that the block must ignore
    task automatic send_eoi();
        send_beat(8'($urandom_range(255)), 1'b1);
    endtask

    // sender stops and waits for every owed token
    task automatic drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
    endtask

    function automatic logic [7:0] rand_letter();
        if ($urandom_range(1))
            return 8'("a" + $urandom_range(25));
        return 8'("A" + $urandom_range(25));
    endfunction

    function automatic logic [7:0] rand_digit();
        return 8'("0" + $urandom_range(9));
    endfunction

    // one well-formed lexeme with random content; lexemes run into each other
    // freely, which also gives the broken joins (number then name, '=' then eof)
    task automatic send_random_token();
        int pick;
        int len;
        pick = $urandom_range(99);
        if (pick < 20) begin
            // mostly short numbers, some long enough to saturate
            len = ($urandom_range(9) < 8) ? $urandom_range(4, 1) : $urandom_range(14, 9);
            repeat (len) send_char(rand_digit());
        end else if (pick < 38) begin
            send_char(rand_letter());
            repeat ($urandom_range(6)) begin
                if ($urandom_range(2) == 0)
                    send_char(rand_digit());
                else
                    send_char(rand_letter());
            end
        end else if (pick < 52) begin
            send_char(single_syms[$urandom_range(single_syms.len() - 1)]);
        end else if (pick < 64) begin
            send_char(rel_syms[$urandom_range(2)]);
            if ($urandom_range(1))
                send_char(CH_EQ);
        end else if (pick < 72) begin
            // any byte at all may follow the bang
            send_char("!");
            send_char(8'($urandom_range(255)));
        end else if (pick < 86) begin
            case ($urandom_range(4))
                0: send_char(CH_SP);
                1: send_char(CH_TAB);
                2: send_char(CH_VT);
                3: send_char(CH_FF);
                default: send_char(CH_CR);
            endcase
        end else if (pick < 95) begin
            send_char(CH_NL);
        end else begin
            send_eoi();
        end
    endtask

    task automatic random_phase(int n);
        int target;
        target = items_sent + n;
        while (items_sent < target)
            send_random_token();
    endtask

    initial begin
        sb = new();
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed opening: names, numbers, every pending mode, bang with byte
        // extremes, flushes at end of input
        send_char("a");
        send_char("b");
        send_char("1");
        send_char(CH_SP);
        send_char("4");
        send_char("2");
        send_char(CH_NL);
        send_char(CH_EQ);
        send_char(CH_EQ);
        send_char("!");
        send_char(8'h00);
        send_char("!");
        send_char(8'hFF);
        send_char(">");
        send_char("5");
        send_char("<");
        send_char(CH_EQ);
        send_char(CH_TAB);
        send_char(CH_EQ);
        send_char(";");
        send_char("!");
        send_eoi();
        send_char("x");
        send_eoi();
        drain();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  out_stall_pct = 0;  end
                1: begin send_idle_pct = 57; out_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  out_stall_pct = 57; end
                default: begin send_idle_pct = 7; out_stall_pct = 7; end
            endcase
            if (phase == 0) begin
                // receiver holds off while the sender keeps offering beats,
                // so the queue fills and the input stalls
                random_phase(ITEMS_PER_PHASE / 4);
                hold_reqs++;
                random_phase(ITEMS_PER_PHASE - ITEMS_PER_PHASE / 4);
            end else begin
                random_phase(ITEMS_PER_PHASE);
            end
            drain();
        end

        // unknown byte halts the block; everything after it, end of input too,
        // gives nothing
        send_idle_pct = 0;
        out_stall_pct = 0;
        if ($urandom_range(1))
            send_char(8'($urandom_range(255, 128)));
        else
            send_char("#");
        random_phase(8);
        send_eoi();
        drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("Verification failed");
        $finish;
    end

endmodule
